// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define FBPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset
`define FBPA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, codes and fixed widths of the block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int BIDX_W = 6;
  localparam int STAT_W = 2;
  localparam int RIDX_W = 6;
  localparam int OFS_W  = 18;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;
  localparam int BSZ_W  = 13;

  // Configuration port
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 13;
  localparam logic [CFG_IW-1:0] REG_POOL_CAPACITY = 1'd0;
  localparam logic [CFG_IW-1:0] REG_BLOCK_SIZE    = 1'd1;
  localparam logic [CAP_W-1:0]  CAP_RESET         = 7'd64;
  localparam logic [BSZ_W-1:0]  BSZ_RESET         = 13'd64;

  // Internal block index: capacity never exceeds 127, so 7 bits cover
  // every reachable block.
  localparam int IXW    = 7;
  localparam int WORD_W = 32;
  localparam int BW     = 5;
  localparam int WSW    = IXW - BW;

  typedef logic [IXW-1:0] blk_ix_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_FIRST   = 2'd2,
    FN_NEXT    = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Request to the word scanner
  typedef struct packed {
    logic             want;
    logic [WSW-1:0]   wsel;
    blk_ix_t          from;
    blk_ix_t          cap;
  } scan_req_t;

  // Scanner answer
  typedef struct packed {
    logic    found;
    blk_ix_t pos;
  } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/core/fbpa_req_if.sv
// ----------------------------------------------------------------------------
// fbpa_req_if
// Request channel: function code and block index, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_req_if import fbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BIDX_W-1:0] block_index;

  modport source (output valid, output func, output block_index, input ready);
  modport sink   (input valid, input func, input block_index, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fbpa_rsp_if.sv
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Result channel: status, index, byte offset and used count.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [RIDX_W-1:0] result_index;
  logic [OFS_W-1:0]  byte_offset;
  logic [CNT_W-1:0]  used_total;

  modport source (output valid, output status, output result_index,
                  output byte_offset, output used_total, input ready);
  modport sink   (input valid, input status, input result_index,
                  input byte_offset, input used_total, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// First-fit allocator over a pool of equal-size blocks.
// ----------------------------------------------------------------------------
// The used map sits in a RAM of 32-bit words (one bit per block) with a
// registered read; one row-valid flop per word makes the map read as all
// free after reset, so no clearing pass is needed. An accepted request is
// finished before the next one can be accepted; the time it takes grows with
// the number of map words the scan visits: one for a release, up to
// ceil(capacity / 32) for allocate and the searches, and zero when the
// answer follows from the count or the capacity alone. The result sits in
// an output register, so a new request is taken while the previous result
// waits to be read.
// Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none

`include "assert_macros.svh"

module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  fbpa_req_if.sink               req,
  fbpa_rsp_if.source             rsp
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [CAP_W-1:0] pool_capacity;
  logic [BSZ_W-1:0] block_size;

  // request context
  func_t          func_q;
  blk_ix_t        from_q;
  logic [WSW-1:0] wsel, wsel_next;
  status_t        status_q, status_next;
  blk_ix_t        res_q, res_next;
  logic [CNT_W-1:0] used_count, used_count_next;

  // map storage
  logic                row_valid [NUM_WORDS];
  logic [AW-1:0]       rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic [WORD_W-1:0]   word;
  logic                mem_we;
  logic [WORD_W-1:0]   mem_wdata;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [RIDX_W-1:0] out_index;
  logic [OFS_W-1:0]  out_offset;
  logic [CNT_W-1:0]  out_total;

  blk_ix_t   cap, cap_m1, idx_in, nxt_in, from_in;
  logic [WSW-1:0] last_w;
  logic      early;
  status_t   early_status;
  func_t     func_in;
  scan_req_t scan_req;
  scan_res_t scan_res;
  logic [BSZ_W+IXW-1:0] prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_capacity <= CAP_RESET;
      block_size    <= BSZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_CAPACITY: pool_capacity <= cfg_data[CAP_W-1:0];
        REG_BLOCK_SIZE:    block_size    <= cfg_data[BSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // active capacity and last reachable word
  always_comb begin
    if (int'(pool_capacity) > NUM_BLOCKS) begin
      cap = IXW'(NUM_BLOCKS);
    end else begin
      cap = pool_capacity;
    end
  end
  assign cap_m1 = cap - IXW'(1);
  assign last_w = cap_m1[IXW-1:BW];

  // decode of the incoming request: answers that need no map read
  assign func_in = func_t'(req.func);
  assign idx_in  = {1'b0, req.block_index};
  assign nxt_in  = idx_in + IXW'(1);

  always_comb begin
    early        = 1'b0;
    early_status = ST_NONE;
    from_in      = '0;
    unique case (func_in)
      FN_ALLOC: begin
        early = (used_count >= cap);
      end
      FN_RELEASE: begin
        early        = (idx_in >= cap);
        early_status = ST_BAD;
        from_in      = idx_in;
      end
      FN_FIRST: begin
        early = (used_count == '0) || (cap == '0);
      end
      FN_NEXT: begin
        early   = (nxt_in >= cap);
        from_in = nxt_in;
      end
      default: ;
    endcase
  end

  // map word read this cycle; rows never written read as free
  assign word = row_valid[AW'(wsel)] ? rd_data : '0;

  // read address: first word on accept, next word while scanning
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = AW'(from_in[IXW-1:BW]);
      S_SCAN:  rd_addr = AW'(wsel + WSW'(1));
      default: rd_addr = AW'(wsel);
    endcase
  end

  fbpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(wsel)),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign scan_req.want = (func_q != FN_ALLOC);
  assign scan_req.wsel = wsel;
  assign scan_req.from = from_q;
  assign scan_req.cap  = cap;

  fbpa_scan u_scan (
    .word (word),
    .req  (scan_req),
    .res  (scan_res)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    wsel_next       = wsel;
    status_next     = status_q;
    res_next        = res_q;
    used_count_next = used_count;
    mem_we          = 1'b0;
    mem_wdata       = word;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          wsel_next   = from_in[IXW-1:BW];
          status_next = early_status;
          res_next    = '0;
          state_next  = early ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (func_q == FN_RELEASE) begin
          // single word: test and clear the addressed bit
          if (word[from_q[BW-1:0]]) begin
            mem_we                     = 1'b1;
            mem_wdata[from_q[BW-1:0]]  = 1'b0;
            used_count_next            = used_count - CNT_W'(1);
            status_next                = ST_OK;
            res_next                   = from_q;
          end else begin
            status_next = ST_BAD;
          end
          state_next = S_DONE;
        end else if (scan_res.found) begin
          if (func_q == FN_ALLOC) begin
            mem_we                          = 1'b1;
            mem_wdata[scan_res.pos[BW-1:0]] = 1'b1;
            used_count_next                 = used_count + CNT_W'(1);
          end
          status_next = ST_OK;
          res_next    = scan_res.pos;
          state_next  = S_DONE;
        end else if (wsel == last_w) begin
          status_next = ST_NONE;
          state_next  = S_DONE;
        end else begin
          wsel_next = wsel + WSW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
    end
  end

  // request context, no reset needed
  always_ff @(posedge clk) begin
    wsel     <= wsel_next;
    status_q <= status_next;
    res_q    <= res_next;
    if (state == S_IDLE && req.valid) begin
      func_q <= func_in;
      from_q <= from_in;
    end
  end

  // row valid bits: a row holds real data once written
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        row_valid[w] <= 1'b0;
      end
    end else if (mem_we) begin
      row_valid[AW'(wsel)] <= 1'b1;
    end
  end

  // offset product, registered in the output stage
  assign prod = (BSZ_W+IXW)'(res_q) * (BSZ_W+IXW)'(block_size);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_status <= status_q;
      out_index  <= res_q[RIDX_W-1:0];
      out_offset <= prod[OFS_W-1:0];
      out_total  <= used_count;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_index = out_index;
  assign rsp.byte_offset  = out_offset;
  assign rsp.used_total   = out_total;

  // checks; the count step is only compared once the previous edge was out of reset
  `FBPA_ASSERT(a_count_bound, int'(used_count) <= NUM_BLOCKS, "used count above pool size")
  `FBPA_ASSERT(a_we_in_scan, mem_we |-> state == S_SCAN, "map written outside scan")
  `FBPA_ASSERT(a_accept_busy, (req.valid && req.ready) |=> state != S_IDLE, "accept lost")
  `FBPA_ASSERT(a_fail_zero,
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.result_index == '0 && rsp.byte_offset == '0),
    "failed result not zero")
  `FBPA_NEVER(a_count_jump,
    !$past(rst) && (used_count - $past(used_count) + CNT_W'(1) > CNT_W'(2)),
    "count moved by more than one")

endmodule

`default_nettype wire

// File: rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/fbpa_scan.sv
// ----------------------------------------------------------------------------
// fbpa_scan
// Finds the lowest bit of one map word that matches the wanted value and
// lies in the window [from, cap).
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_scan import fbpa_pkg::*; (
  input  wire logic [WORD_W-1:0] word,
  input  wire scan_req_t         req,
  output scan_res_t              res
);

  logic [WORD_W-1:0] cand;
  logic [BW-1:0]     low;

  // candidate bits: matching value and inside the window
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = (req.want ? word[b] : ~word[b])
                && ({req.wsel, BW'(b)} >= req.from)
                && ({req.wsel, BW'(b)} <  req.cap);
    end
  end

  // lowest candidate
  always_comb begin
    low = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        low = BW'(b);
      end
    end
  end

  assign res.found = |cand;
  assign res.pos   = {req.wsel, low};

endmodule

`default_nettype wire

// File: verif/fixed_block_pool_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core_tb
// Self-checking bench for the first-fit block pool allocator. A clocked driver
// feeds allocate, release and search requests from a queue. A clocked monitor
// runs a pool model on every accepted word and checks each result in order.
// Both channels get random idle bursts. The pool settings change only while
// the block is idle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core_tb;
  import fbpa_pkg::*;

  localparam int POOL_BLOCKS = 64;

  typedef struct packed {
    func_t             fn;
    logic [BIDX_W-1:0] index;
  } pool_op_t;

  typedef struct packed {
    status_t           status;
    logic [RIDX_W-1:0] index;
    logic [OFS_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
  } pool_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator_core #(.NUM_BLOCKS(POOL_BLOCKS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #2 clk = ~clk;

  // Pool model state and its copy of the settings
  logic [POOL_BLOCKS-1:0] pool_used = '0;
  int                     pool_used_count = 0;
  logic [CAP_W-1:0]       pool_cap = CAP_RESET;
  logic [BSZ_W-1:0]       blk_bytes = BSZ_RESET;

  pool_op_t     op_q[$];
  pool_result_t expected_q[$];
  int           ops_queued = 0;
  int           ops_accepted = 0;
  int           mismatch_count = 0;
  int           settings_used = 1;
  int           status_seen[3] = '{0, 0, 0};
  bit           quiet_tail = 1'b0;
  int           send_gap;
  int           stall_left;
  pool_op_t     next_op;
  pool_result_t want_res;

  // Lowest block in [from, lim) whose used bit equals want; lim when none
  function automatic int find_block(int from, int lim, logic want);
    for (int i = from; i < lim; i++)
      if (pool_used[i] == want) return i;
    return lim;
  endfunction

  // Apply one request to the pool model and form its result word
  function automatic pool_result_t apply_pool_op(func_t fn, logic [BIDX_W-1:0] bi);
    pool_result_t r;
    int           lim;
    int           pos;
    int           hit;
    logic [31:0]  prod;
    lim = (pool_cap > POOL_BLOCKS) ? POOL_BLOCKS : int'(pool_cap);
    r.status = ST_NONE;
    pos = 0;
    case (fn)
      FN_ALLOC: begin
        if (pool_used_count < lim) begin
          hit = find_block(0, lim, 1'b0);
          if (hit < lim) begin
            pool_used[hit] = 1'b1;
            pool_used_count++;
            r.status = ST_OK;
            pos = hit;
          end
        end
      end
      FN_RELEASE: begin
        if (int'(bi) < lim && pool_used[bi]) begin
          pool_used[bi] = 1'b0;
          pool_used_count--;
          r.status = ST_OK;
          pos = int'(bi);
        end else begin
          r.status = ST_BAD;
        end
      end
      FN_FIRST: begin
        if (pool_used_count != 0) begin
          hit = find_block(0, lim, 1'b1);
          if (hit < lim) begin
            r.status = ST_OK;
            pos = hit;
          end
        end
      end
      FN_NEXT: begin
        if (int'(bi) + 1 < lim) begin
          hit = find_block(int'(bi) + 1, lim, 1'b1);
          if (hit < lim) begin
            r.status = ST_OK;
            pos = hit;
          end
        end
      end
    endcase
    prod = pos * blk_bytes;
    r.index  = pos[RIDX_W-1:0];
    r.offset = prod[OFS_W-1:0];
    r.count  = pool_used_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_op(func_t fn, int bi);
    op_q.push_back('{fn: fn, index: bi[BIDX_W-1:0]});
    ops_queued++;
  endtask

  // Wait until every queued word is taken and every result has come back
  task automatic drain();
    while (ops_accepted != ops_queued || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] ix, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (ix == REG_POOL_CAPACITY) pool_cap = val[CAP_W-1:0];
    else blk_bytes = val[BSZ_W-1:0];
  endtask

  task automatic set_pool(int cap, int bsz);
    drain();
    write_reg(REG_POOL_CAPACITY, cap[CFG_DW-1:0]);
    write_reg(REG_BLOCK_SIZE, bsz[CFG_DW-1:0]);
    settings_used++;
  endtask

  // Random traffic: mostly allocate runs, release runs and search walks
  task automatic push_random_ops(int n);
    int made;
    int lim;
    int k;
    int mode;
    made = 0;
    lim = (pool_cap > POOL_BLOCKS) ? POOL_BLOCKS : int'(pool_cap);
    if (lim == 0) lim = POOL_BLOCKS;
    while (made < n) begin
      mode = $urandom_range(0, 9);
      k = $urandom_range(1, 12);
      for (int j = 0; j < k; j++) begin
        if (mode <= 3) push_op(FN_ALLOC, 0);
        else if (mode <= 6) push_op(FN_RELEASE, $urandom_range(0, lim - 1));
        else if (mode == 7) begin
          if (j == 0) push_op(FN_FIRST, $urandom_range(0, 63));
          else push_op(FN_NEXT, $urandom_range(0, lim - 1));
        end else if (mode == 8) push_op(FN_NEXT, $urandom_range(0, lim - 1));
        else push_op(func_t'($urandom_range(0, 3)), $urandom_range(0, 63));
      end
      made += k;
    end
  endtask

  // Request driver: next word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 18) - 1;
        req_ch.valid <= 1'b0;
      end else if (op_q.size() != 0) begin
        next_op = op_q.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.func        <= next_op.fn;
        req_ch.block_index <= next_op.index;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(apply_pool_op(func_t'(req_ch.func), req_ch.block_index));
        ops_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word, status", rsp_ch.status, -1);
        end else begin
          want_res = expected_q.pop_front();
          if (rsp_ch.status != want_res.status)
            report_mismatch("status", rsp_ch.status, want_res.status);
          if (rsp_ch.result_index != want_res.index)
            report_mismatch("result_index", rsp_ch.result_index, want_res.index);
          if (rsp_ch.byte_offset != want_res.offset)
            report_mismatch("byte_offset", rsp_ch.byte_offset, want_res.offset);
          if (rsp_ch.used_total != want_res.count)
            report_mismatch("used_total", rsp_ch.used_total, want_res.count);
          if (want_res.status <= ST_BAD) status_seen[want_res.status]++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.func = '0;
    req_ch.block_index = '0;
    rsp_ch.ready = 1'b0;

    // Empty pool: searches find nothing, releases are rejected
    push_op(FN_FIRST, 0);
    push_op(FN_NEXT, 63);
    push_op(FN_NEXT, 0);
    push_op(FN_RELEASE, 0);
    push_op(FN_RELEASE, 63);
    // Fill a few, walk them, free one and take it back
    push_op(FN_ALLOC, 0);
    push_op(FN_ALLOC, 0);
    push_op(FN_ALLOC, 0);
    push_op(FN_FIRST, 0);
    push_op(FN_NEXT, 0);
    push_op(FN_NEXT, 2);
    push_op(FN_RELEASE, 1);
    push_op(FN_RELEASE, 1);
    push_op(FN_ALLOC, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Capacity lowered below the count: full, out-of-range release, short walk
    set_pool(2, 64);
    push_op(FN_ALLOC, 0);
    push_op(FN_RELEASE, 2);
    push_op(FN_FIRST, 0);
    push_op(FN_NEXT, 0);
    push_op(FN_NEXT, 1);

    // Zero capacity: nothing is reachable
    set_pool(0, 64);
    push_op(FN_ALLOC, 0);
    push_op(FN_FIRST, 0);
    push_op(FN_RELEASE, 0);

    // Random phases over a spread of settings, widest offsets first
    set_pool(127, 8191);
    push_random_ops(200);
    set_pool(1, 1);
    push_random_ops(60);
    set_pool(64, 4096);
    push_random_ops(200);
    set_pool(40, 0);
    push_random_ops(150);
    set_pool(0, 300);
    push_random_ops(20);
    set_pool(33, 7);
    push_random_ops(150);
    set_pool(64, 64);
    quiet_tail = 1'b1;
    push_random_ops(200);

    drain();
    $display("Checked %0d requests over %0d pool settings.", ops_accepted, settings_used);
    $display("Results: %0d ok, %0d full or not found, %0d rejected releases.",
             status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_BAD]);
    if (mismatch_count == 0) begin
      $display("PASS fixed_block_pool_allocator_core");
    end else begin
      $display("FAIL fixed_block_pool_allocator_core");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("FAIL fixed_block_pool_allocator_core");
    $finish;
  end

endmodule
